@@ rtl/gbg_pkg.sv @@
// ----------------------------------------------------------------------------
// gbg_pkg: shared definitions for the glyph blitter
// Field widths, reset values, register indexes and the structs that travel
// between the front end, the queue and the color back end.
// ----------------------------------------------------------------------------
package gbg_pkg;

  // Defaults for the top-level parameters.
  localparam int SCREEN_WIDTH_DEF   = 1920;
  localparam int SCREEN_HEIGHT_DEF  = 1080;
  localparam int RAMP_STEPS_DEF     = 8;
  localparam int GLYPH_MAX_SIDE_DEF = 256;

  // Fixed field widths.
  localparam int COVERAGE_W  = 8;
  localparam int PIX_COORD_W = 11;
  localparam int COLOR_W     = 32;
  localparam int ORIGIN_W    = 13;
  localparam int GEOM_W      = 9;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  // Signed screen coordinate: 13-bit origin plus a glyph offset below 1024.
  localparam int COORD_W     = 14;
  // Ramp index width for the largest ramp (16 steps).
  localparam int RAMP_IDX_W  = 4;
  // Depth of the queue between front and back end (power of two).
  localparam int FIFO_DEPTH  = 4;

  localparam logic [COVERAGE_W-1:0] COV_SPLIT    = 8'h80;
  localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;
  localparam logic [COLOR_W-1:0]    START_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0]    END_COLOR_RST   = 32'hFF40_4040;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_GLYPH_WIDTH = 3'd2,
    CFG_GLYPH_ROWS  = 3'd3,
    CFG_START_COLOR = 3'd4,
    CFG_END_COLOR   = 3'd5
  } gbg_cfg_idx_t;

  // Placement and geometry seen by the front end; clear restarts the walk.
  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [GEOM_W-1:0]   glyph_width;
    logic [GEOM_W-1:0]   glyph_rows;
    logic                clear;
  } gbg_geom_t;

  // One pixel write waiting for its color.
  typedef struct packed {
    logic [PIX_COORD_W-1:0] pixel_x;
    logic [PIX_COORD_W-1:0] pixel_y;
    logic                   grad;
    logic [COVERAGE_W-1:0]  coverage;
    logic [RAMP_IDX_W-1:0]  ramp_k;
  } gbg_entry_t;

endpackage

@@ rtl/gbg_if.sv @@
// ----------------------------------------------------------------------------
// gbg_if: valid/ready channels of the glyph blitter
// Coverage input channel and pixel write output channel.
// ----------------------------------------------------------------------------
interface gbg_in_if;
  logic                             valid;
  logic                             ready;
  logic [gbg_pkg::COVERAGE_W-1:0]   coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

interface gbg_out_if;
  logic                             valid;
  logic                             ready;
  logic [gbg_pkg::PIX_COORD_W-1:0]  pixel_x;
  logic [gbg_pkg::PIX_COORD_W-1:0]  pixel_y;
  logic [gbg_pkg::COLOR_W-1:0]      pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  output ready);
endinterface

@@ rtl/gbg_front.sv @@
// ----------------------------------------------------------------------------
// gbg_front: glyph walker and pixel classifier
// Tracks column and row within the glyph, places each beat on the screen,
// and forwards only visible, non-empty pixels to the queue.
// ----------------------------------------------------------------------------
module gbg_front #(
  parameter int SCREEN_WIDTH   = gbg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = gbg_pkg::SCREEN_HEIGHT_DEF,
  parameter int RAMP_STEPS     = gbg_pkg::RAMP_STEPS_DEF,
  parameter int GLYPH_MAX_SIDE = gbg_pkg::GLYPH_MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gbg_pkg::gbg_geom_t               geom,
  input  logic                             in_fire,
  input  logic [gbg_pkg::COVERAGE_W-1:0]   coverage,
  output logic                             push,
  output gbg_pkg::gbg_entry_t              entry
);

  localparam int LW    = $clog2(GLYPH_MAX_SIDE + 1);
  localparam int CMP_W = (LW > gbg_pkg::GEOM_W) ? LW : gbg_pkg::GEOM_W;
  localparam int CW    = gbg_pkg::COORD_W;
  localparam int KW    = gbg_pkg::RAMP_IDX_W;
  localparam logic [KW-1:0] K_MAX = KW'(RAMP_STEPS - 1);

  // Zero counts as one, anything above the maximum counts as the maximum.
  function automatic logic [LW-1:0] side_limit(input logic [gbg_pkg::GEOM_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) return LW'(1);
    if (w > CMP_W'(GLYPH_MAX_SIDE)) return LW'(GLYPH_MAX_SIDE);
    return LW'(w);
  endfunction

  logic [LW-1:0] col_r, col_nxt;
  logic [LW-1:0] row_r, row_nxt;
  logic [1:0]    sub3_r, sub3_nxt;   // row modulo 3
  logic [KW-1:0] k_r, k_nxt;         // min(row / 3, RAMP_STEPS - 1)
  logic [LW-1:0] cols_lim, rows_lim;
  logic          row_wrap, col_wrap;
  logic          is_grey, is_grad, on_screen;
  logic signed [CW-1:0] px, py;

  assign cols_lim = side_limit(geom.glyph_width);
  assign rows_lim = side_limit(geom.glyph_rows);
  assign row_wrap = ((LW+1)'(row_r) + (LW+1)'(1)) >= (LW+1)'(rows_lim);
  assign col_wrap = ((LW+1)'(col_r) + (LW+1)'(1)) >= (LW+1)'(cols_lim);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    sub3_nxt = sub3_r;
    k_nxt    = k_r;
    if (geom.clear) begin
      col_nxt  = '0;
      row_nxt  = '0;
      sub3_nxt = '0;
      k_nxt    = '0;
    end else if (in_fire) begin
      if (row_wrap) begin
        row_nxt  = '0;
        sub3_nxt = '0;
        k_nxt    = '0;
        col_nxt  = col_wrap ? '0 : col_r + LW'(1);
      end else begin
        row_nxt = row_r + LW'(1);
        if (sub3_r == 2'd2) begin
          sub3_nxt = '0;
          if (k_r != K_MAX) k_nxt = k_r + KW'(1);
        end else begin
          sub3_nxt = sub3_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      sub3_r <= '0;
      k_r    <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      sub3_r <= sub3_nxt;
      k_r    <= k_nxt;
    end
  end

  assign px = CW'($signed(geom.origin_x)) + $signed(CW'(col_r));
  assign py = CW'($signed(geom.origin_y)) + $signed(CW'(row_r));

  assign on_screen = !px[CW-1] && (px < $signed(CW'(SCREEN_WIDTH))) &&
                     !py[CW-1] && (py < $signed(CW'(SCREEN_HEIGHT)));

  assign is_grey = (coverage != '0) && (coverage < gbg_pkg::COV_SPLIT);
  assign is_grad = coverage > gbg_pkg::COV_SPLIT;

  assign push = in_fire && (is_grey || is_grad) && on_screen;

  always_comb begin
    entry.pixel_x  = px[gbg_pkg::PIX_COORD_W-1:0];
    entry.pixel_y  = py[gbg_pkg::PIX_COORD_W-1:0];
    entry.grad     = is_grad;
    entry.coverage = coverage;
    entry.ramp_k   = k_r;
  end

  // The walk never leaves the glyph and the ramp index tracks the row.
  a_row_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < rows_lim) else $error("row counter outside glyph");
  a_col_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < cols_lim) else $error("column counter outside glyph");
  a_ramp_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == '0) |-> (k_r == '0 && sub3_r == '0))
    else $error("ramp index not restarted with row");

endmodule

@@ rtl/gbg_fifo.sv @@
// ----------------------------------------------------------------------------
// gbg_fifo: pixel queue between front and back end
// Small circular buffer that lets either side stall independently.
// ----------------------------------------------------------------------------
module gbg_fifo #(
  parameter int DEPTH = gbg_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gbg_pkg::gbg_entry_t  din,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output gbg_pkg::gbg_entry_t  dout
);

  localparam int AW = $clog2(DEPTH);

  gbg_pkg::gbg_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full  = count_r == (AW+1)'(DEPTH);
  assign valid = count_r != '0;
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid)) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/gbg_back.sv @@
// ----------------------------------------------------------------------------
// gbg_back: color back end
// Two-stage pipeline: weighted channel sums, then an exact divide by the
// ramp denominator through a reciprocal multiply, into the output register.
// ----------------------------------------------------------------------------
module gbg_back #(
  parameter int RAMP_STEPS = gbg_pkg::RAMP_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbg_pkg::COLOR_W-1:0]   start_color,
  input  logic [gbg_pkg::COLOR_W-1:0]   end_color,
  input  logic                          entry_valid,
  input  gbg_pkg::gbg_entry_t           entry,
  output logic                          pop,
  gbg_out_if.source                     out_beat
);

  localparam int DEN    = RAMP_STEPS - 1;
  localparam int IW     = $clog2(RAMP_STEPS);
  localparam int SUM_W  = 8 + IW;
  // Reciprocal with enough fraction bits to be exact for every sum.
  localparam int SHIFT  = SUM_W + 2 * IW;
  localparam int RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + DEN - 1) / DEN);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int XW     = gbg_pkg::PIX_COORD_W;

  logic                          a_valid_r;
  logic [XW-1:0]                 a_x_r, a_y_r;
  logic                          a_grad_r;
  logic [gbg_pkg::COLOR_W-1:0]   a_grey_r;
  logic [SUM_W-1:0]              a_sum_r [4];
  logic [SUM_W-1:0]              sum_nxt [4];

  logic                          b_valid_r;
  logic [XW-1:0]                 b_x_r, b_y_r;
  logic [gbg_pkg::COLOR_W-1:0]   b_color_r, color_nxt;

  logic          adv_a, adv_b;
  logic [IW-1:0] w_end, w_start;
  logic [PROD_W-1:0] prod [4];

  assign adv_b = !b_valid_r || out_beat.ready;
  assign adv_a = !a_valid_r || adv_b;
  assign pop   = entry_valid && adv_a;

  assign w_end   = IW'(entry.ramp_k);
  assign w_start = IW'(DEN) - w_end;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_nxt[c] = SUM_W'(start_color[8*c +: 8]) * SUM_W'(w_start) +
                   SUM_W'(end_color[8*c +: 8]) * SUM_W'(w_end);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv_a) begin
      a_valid_r <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_x_r    <= entry.pixel_x;
      a_y_r    <= entry.pixel_y;
      a_grad_r <= entry.grad;
      a_grey_r <= {gbg_pkg::ALPHA_OPAQUE, entry.coverage, entry.coverage, entry.coverage};
      for (int c = 0; c < 4; c++) a_sum_r[c] <= sum_nxt[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = PROD_W'(a_sum_r[c]) * PROD_W'(RECIP);
    end
    color_nxt = a_grey_r;
    if (a_grad_r) begin
      color_nxt = {prod[3][SHIFT +: 8], prod[2][SHIFT +: 8],
                   prod[1][SHIFT +: 8], prod[0][SHIFT +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid_r) begin
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_color_r <= color_nxt;
    end
  end

  assign out_beat.valid       = b_valid_r;
  assign out_beat.pixel_x     = b_x_r;
  assign out_beat.pixel_y     = b_y_r;
  assign out_beat.pixel_color = b_color_r;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_beat.ready) |=> (b_valid_r && $stable(b_color_r)))
    else $error("output register changed under stall");
  a_stage_a_held: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !adv_a) |=> a_valid_r) else $error("stage A dropped a beat");
  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!a_valid_r || !b_valid_r || out_beat.ready))
    else $error("queue popped into a full pipeline");

endmodule

@@ rtl/glyph_blit_gradient.sv @@
// ----------------------------------------------------------------------------
// glyph_blit_gradient: glyph coverage blitter with screen clipping
// Turns a column-major stream of glyph coverage bytes into pixel writes:
// grey for low coverage, a vertical color ramp for high coverage.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  in_beat   in   valid/ready        coverage[7:0]
//  out_beat  out  valid/ready        pixel_x[10:0], pixel_y[10:0], pixel_color[31:0]
//  cfg_*     in   cfg_we, no stall   cfg_index[2:0], cfg_data[31:0]
//
//  One coverage beat is accepted every cycle while the four-entry queue has
//  room. A visible pixel passes through the queue, the channel-sum stage
//  and the reciprocal-multiply stage on its way to out_beat; a stall can
//  hold it in any of them. Beats that write nothing leave no trace downstream.
//  Reset is synchronous and active low; it clears counters, queue and valids
//  and loads the register reset values. A stall on out_beat fills the
//  pipeline and then the queue before in_beat.ready drops.
//
module glyph_blit_gradient #(
  parameter int SCREEN_WIDTH   = gbg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = gbg_pkg::SCREEN_HEIGHT_DEF,
  parameter int RAMP_STEPS     = gbg_pkg::RAMP_STEPS_DEF,
  parameter int GLYPH_MAX_SIDE = gbg_pkg::GLYPH_MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gbg_in_if.sink                            in_beat,
  gbg_out_if.source                         out_beat,
  input  logic                              cfg_we,
  input  logic [gbg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gbg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers. Glyph width and row writes also restart the glyph walk.
  logic [gbg_pkg::ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic [gbg_pkg::GEOM_W-1:0]   glyph_width_r, glyph_rows_r;
  logic [gbg_pkg::COLOR_W-1:0]  start_color_r, end_color_r;
  logic                         geom_clear;

  gbg_pkg::gbg_geom_t  geom;
  gbg_pkg::gbg_entry_t push_entry, head_entry;
  logic in_fire, push, fifo_full, fifo_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      glyph_width_r <= gbg_pkg::GEOM_W'(1);
      glyph_rows_r  <= gbg_pkg::GEOM_W'(1);
      start_color_r <= gbg_pkg::START_COLOR_RST;
      end_color_r   <= gbg_pkg::END_COLOR_RST;
    end else if (cfg_we) begin
      unique case (gbg_pkg::gbg_cfg_idx_t'(cfg_index))
        gbg_pkg::CFG_ORIGIN_X:    origin_x_r    <= cfg_data[gbg_pkg::ORIGIN_W-1:0];
        gbg_pkg::CFG_ORIGIN_Y:    origin_y_r    <= cfg_data[gbg_pkg::ORIGIN_W-1:0];
        gbg_pkg::CFG_GLYPH_WIDTH: glyph_width_r <= cfg_data[gbg_pkg::GEOM_W-1:0];
        gbg_pkg::CFG_GLYPH_ROWS:  glyph_rows_r  <= cfg_data[gbg_pkg::GEOM_W-1:0];
        gbg_pkg::CFG_START_COLOR: start_color_r <= cfg_data;
        gbg_pkg::CFG_END_COLOR:   end_color_r   <= cfg_data;
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  assign geom_clear =
    cfg_we && ((gbg_pkg::gbg_cfg_idx_t'(cfg_index) == gbg_pkg::CFG_GLYPH_WIDTH) ||
               (gbg_pkg::gbg_cfg_idx_t'(cfg_index) == gbg_pkg::CFG_GLYPH_ROWS));

  always_comb begin
    geom.origin_x    = origin_x_r;
    geom.origin_y    = origin_y_r;
    geom.glyph_width = glyph_width_r;
    geom.glyph_rows  = glyph_rows_r;
    geom.clear       = geom_clear;
  end

  // Every beat is accepted while the queue has room, including the ones
  // that end up writing nothing.
  assign in_beat.ready = !fifo_full;
  assign in_fire       = in_beat.valid && !fifo_full;

  gbg_front #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .RAMP_STEPS     (RAMP_STEPS),
    .GLYPH_MAX_SIDE (GLYPH_MAX_SIDE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_fire  (in_fire),
    .coverage (in_beat.coverage),
    .push     (push),
    .entry    (push_entry)
  );

  gbg_fifo #(
    .DEPTH (gbg_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_entry),
    .full  (fifo_full),
    .pop   (pop),
    .valid (fifo_valid),
    .dout  (head_entry)
  );

  gbg_back #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .entry_valid (fifo_valid),
    .entry       (head_entry),
    .pop         (pop),
    .out_beat    (out_beat)
  );

endmodule

@@ test/glyph_blit_gradient_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blit_gradient_tb: self-checking bench for the glyph coverage blitter
// Streams coverage beats through the valid/ready input channel and compares
// every pixel write with a cycle-free model of the column/row walk, screen
// clipping, grey mapping and the vertical color ramp, or with a write typed
// into a short table of directed rows that comes first. Random glyph setups
// and random traffic with stalls on both channels follow.
// ----------------------------------------------------------------------------
module glyph_blit_gradient_tb;

  localparam int  CLK_HALF_NS     = 2;
  localparam int  RESET_CYCLES    = 6;
  localparam int  DRAIN_CYCLES    = 8;
  localparam int  RX_HOLD_CYCLES  = 60;
  localparam int  PRESSURE_BEATS  = 20;
  localparam int  TARGET_BEATS    = 650;
  localparam int  CALM_BEATS      = 80;
  localparam int  CYCLE_LIMIT     = 300000;
  localparam int  MAX_REPORTS     = 10;
  localparam int  RAMP_LAST       = gbg_pkg::RAMP_STEPS_DEF - 1;

  // The index field is three bits wide, so two indexes map to no register.
  localparam logic [gbg_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [gbg_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [gbg_pkg::PIX_COORD_W-1:0] x;
    logic [gbg_pkg::PIX_COORD_W-1:0] y;
    logic [gbg_pkg::COLOR_W-1:0]     color;
  } pixel_write_t;

  // How a beat's outcome is decided: by the model below, or typed into the
  // directed table as a pixel write or as no write at all.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TYPED_WRITE,
    CHK_TYPED_NONE
  } check_mode_t;

  typedef enum logic {
    ROW_REG,
    ROW_BEAT
  } row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [gbg_pkg::CFG_INDEX_W-1:0] reg_idx;
    logic [gbg_pkg::CFG_DATA_W-1:0]  data;
    logic [gbg_pkg::COVERAGE_W-1:0]  cov;
    check_mode_t                     mode;
    pixel_write_t                    typed;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [gbg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gbg_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Sideband that travels with each input beat, driven like its payload.
  check_mode_t  beat_mode;
  pixel_write_t beat_typed;

  gbg_in_if  in_if ();
  gbg_out_if out_if ();

  glyph_blit_gradient dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_if),
    .out_beat  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model state: a copy of the registers and the glyph walk counters.
  // --------------------------------------------------------------------------
  logic [gbg_pkg::ORIGIN_W-1:0] org_x, org_y;
  logic [gbg_pkg::GEOM_W-1:0]   glyph_w, glyph_h;
  logic [gbg_pkg::COLOR_W-1:0]  ramp_top, ramp_bottom;
  int                           walk_col, walk_row;

  pixel_write_t pending_writes [$];
  int           mismatches;
  int           cycle_count;
  int           beats_sent;

  // Knobs for the random idling on each side, in percent per beat or cycle.
  int send_gap_pct;
  int recv_stall_pct;
  // Each increment asks the result side for one long hold.
  int hold_req;

  directed_row_t plan [$];

  // A side of 0 counts as 1 and anything past the maximum is clamped.
  function automatic int geom_side(input logic [gbg_pkg::GEOM_W-1:0] v);
    if (v == 0) return 1;
    if (v > gbg_pkg::GLYPH_MAX_SIDE_DEF) return gbg_pkg::GLYPH_MAX_SIDE_DEF;
    return int'(v);
  endfunction

  // Works out the pixel write for one coverage byte and advances the walk.
  // Returns 1 when a write is due.
  function automatic bit predict_pixel(input logic [gbg_pkg::COVERAGE_W-1:0] cov,
                                       output pixel_write_t pw);
    int          px, py, k, top_ch, bot_ch;
    bit          paint, visible;
    logic [gbg_pkg::COLOR_W-1:0] color;
    px = int'($signed(org_x)) + walk_col;
    py = int'($signed(org_y)) + walk_row;
    visible = px >= 0 && px < gbg_pkg::SCREEN_WIDTH_DEF &&
              py >= 0 && py < gbg_pkg::SCREEN_HEIGHT_DEF;
    paint = cov != 0 && cov != gbg_pkg::COV_SPLIT;
    if (cov < gbg_pkg::COV_SPLIT) begin
      color = {gbg_pkg::ALPHA_OPAQUE, cov, cov, cov};
    end else begin
      // Ramp step by row, three rows per step, held at the last step.
      k = walk_row / 3;
      if (k > RAMP_LAST) k = RAMP_LAST;
      for (int ch = 0; ch < 4; ch++) begin
        top_ch = int'(ramp_top[8*ch +: 8]);
        bot_ch = int'(ramp_bottom[8*ch +: 8]);
        color[8*ch +: 8] = 8'((top_ch * (RAMP_LAST - k) + bot_ch * k) / RAMP_LAST);
      end
    end
    if (walk_row + 1 >= geom_side(glyph_h)) begin
      walk_row = 0;
      if (walk_col + 1 >= geom_side(glyph_w)) walk_col = 0;
      else walk_col++;
    end else begin
      walk_row++;
    end
    pw.x     = px[gbg_pkg::PIX_COORD_W-1:0];
    pw.y     = py[gbg_pkg::PIX_COORD_W-1:0];
    pw.color = color;
    return paint && visible;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard. Register writes, accepted input beats and accepted output
  // beats are all seen at the same clock edge, in that order, so a prediction
  // is always queued before its pixel write can be compared.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    pixel_write_t predicted, want, got;
    bit           emits;
    if (!rst_n) begin
      org_x       = '0;
      org_y       = '0;
      glyph_w     = gbg_pkg::GEOM_W'(1);
      glyph_h     = gbg_pkg::GEOM_W'(1);
      ramp_top    = gbg_pkg::START_COLOR_RST;
      ramp_bottom = gbg_pkg::END_COLOR_RST;
      walk_col    = 0;
      walk_row    = 0;
      pending_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbg_pkg::CFG_ORIGIN_X:    org_x = cfg_data[gbg_pkg::ORIGIN_W-1:0];
          gbg_pkg::CFG_ORIGIN_Y:    org_y = cfg_data[gbg_pkg::ORIGIN_W-1:0];
          // A geometry write restarts the walk at the top left.
          gbg_pkg::CFG_GLYPH_WIDTH: begin
            glyph_w  = cfg_data[gbg_pkg::GEOM_W-1:0];
            walk_col = 0;
            walk_row = 0;
          end
          gbg_pkg::CFG_GLYPH_ROWS: begin
            glyph_h  = cfg_data[gbg_pkg::GEOM_W-1:0];
            walk_col = 0;
            walk_row = 0;
          end
          gbg_pkg::CFG_START_COLOR: ramp_top    = cfg_data;
          gbg_pkg::CFG_END_COLOR:   ramp_bottom = cfg_data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        emits = predict_pixel(in_if.coverage, predicted);
        case (beat_mode)
          CHK_MODEL:       if (emits) pending_writes.push_back(predicted);
          CHK_TYPED_WRITE: pending_writes.push_back(beat_typed);
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.pixel_x, out_if.pixel_y, out_if.pixel_color};
        if (pending_writes.size() == 0) begin
          flag_mismatch("pixel write with none pending", '0, got.color);
        end else begin
          want = pending_writes.pop_front();
          if (got.x != want.x) flag_mismatch("pixel_x", want.x, got.x);
          if (got.y != want.y) flag_mismatch("pixel_y", want.y, got.y);
          if (got.color != want.color)
            flag_mismatch("pixel_color", want.color, got.color);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side. Ready drops in random bursts, or for one long hold when the
  // stimulus asks for it, so the queue inside the block fills and the input
  // channel has to stall.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_seen;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Offers one beat and returns at the edge that accepts it. Valid stays high
  // into the next beat unless a random gap follows.
  task automatic send_beat(input logic [gbg_pkg::COVERAGE_W-1:0] cov,
                           input check_mode_t mode, input pixel_write_t typed);
    in_if.valid    <= 1'b1;
    in_if.coverage <= cov;
    beat_mode      <= mode;
    beat_typed     <= typed;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stops offering beats, waits for every pending pixel write, then lets the
  // pipeline settle so that beats with no write are out of the block too.
  // The first edge makes sure the scoreboard has logged the last beat.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic write_reg(input logic [gbg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gbg_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void plan_reg(input logic [gbg_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [gbg_pkg::CFG_DATA_W-1:0] data);
    directed_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.data    = data;
    r.cov     = '0;
    r.mode    = CHK_MODEL;
    r.typed   = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_beat(input logic [gbg_pkg::COVERAGE_W-1:0] cov,
                                    input check_mode_t mode, input int x, input int y,
                                    input logic [gbg_pkg::COLOR_W-1:0] color);
    directed_row_t r;
    r.kind    = ROW_BEAT;
    r.reg_idx = '0;
    r.data    = '0;
    r.cov     = cov;
    r.mode    = mode;
    r.typed   = '{gbg_pkg::PIX_COORD_W'(x), gbg_pkg::PIX_COORD_W'(y), color};
    plan.push_back(r);
  endfunction

  // Placement along one axis: often on screen, often hugging either edge,
  // sometimes at the extremes of the 13-bit range or fully random. Negative
  // values carry ones in the upper data bits, which the block must drop.
  function automatic logic [gbg_pkg::CFG_DATA_W-1:0] pick_origin(input int screen_side);
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = int'($urandom_range(0, screen_side - 40));
      3:       v = -int'($urandom_range(0, 24));
      4:       v = screen_side - 24 + int'($urandom_range(0, 30));
      5:       return $urandom_range(0, 1) ? 32'h0000_1000 : 32'h0000_0FFF;
      default: return $urandom();
    endcase
    return gbg_pkg::CFG_DATA_W'(v);
  endfunction

  // Glyph side: small most of the time so the walk wraps often, with the
  // zero, maximum and oversize cases now and then. Upper data bits are sometimes noise.
  function automatic logic [gbg_pkg::CFG_DATA_W-1:0] pick_side(input int small_max);
    logic [gbg_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = '0;
      1:       v = gbg_pkg::GLYPH_MAX_SIDE_DEF;
      2:       v = $urandom_range(gbg_pkg::GLYPH_MAX_SIDE_DEF + 1, 511);
      default: v = $urandom_range(1, small_max);
    endcase
    if ($urandom_range(0, 3) == 0)
      v[gbg_pkg::CFG_DATA_W-1:gbg_pkg::GEOM_W] =
        (gbg_pkg::CFG_DATA_W - gbg_pkg::GEOM_W)'($urandom());
    return v;
  endfunction

  function automatic logic [gbg_pkg::COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Coverage mix: the no-write codes, the grey range and the ramp range.
  function automatic logic [gbg_pkg::COVERAGE_W-1:0] pick_coverage();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return gbg_pkg::COV_SPLIT;
      2, 3, 4:    return gbg_pkg::COVERAGE_W'($urandom_range(1, 127));
      5, 6, 7:    return gbg_pkg::COVERAGE_W'($urandom_range(129, 255));
      default:    return gbg_pkg::COVERAGE_W'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [gbg_pkg::COLOR_W-1:0] top_color;
    int                          phase_beats;
    int                          phase;
    in_if.valid    <= 1'b0;
    in_if.coverage <= '0;
    beat_mode      <= CHK_MODEL;
    beat_typed     <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    beats_sent     = 0;
    hold_req       = 0;
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. From reset the glyph is one pixel at the screen origin
    // and the ramp starts at opaque white, so the first rows are easy to type.
    plan_beat(8'h01, CHK_TYPED_WRITE, 0, 0, 32'hFF01_0101);
    plan_beat(8'h7F, CHK_TYPED_WRITE, 0, 0, 32'hFF7F_7F7F);
    plan_beat(8'h00, CHK_TYPED_NONE, 0, 0, '0);
    plan_beat(8'h80, CHK_TYPED_NONE, 0, 0, '0);
    plan_beat(8'h81, CHK_TYPED_WRITE, 0, 0, gbg_pkg::START_COLOR_RST);
    plan_beat(8'hFF, CHK_TYPED_WRITE, 0, 0, gbg_pkg::START_COLOR_RST);
    // Clipping at the left and right screen edges and at the origin extremes.
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'hFFFF_FFFF);
    plan_beat(8'h40, CHK_TYPED_NONE, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'd1919);
    plan_reg(gbg_pkg::CFG_ORIGIN_Y, 32'd1079);
    plan_beat(8'h40, CHK_TYPED_WRITE, 1919, 1079, 32'hFF40_4040);
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'd1920);
    plan_beat(8'h40, CHK_TYPED_NONE, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'h0000_1000);
    plan_beat(8'hFF, CHK_TYPED_NONE, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'h0000_0FFF);
    plan_beat(8'hFF, CHK_TYPED_NONE, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_ORIGIN_X, 32'd5);
    plan_reg(gbg_pkg::CFG_ORIGIN_Y, 32'h0000_1000);
    plan_beat(8'h01, CHK_TYPED_NONE, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_ORIGIN_Y, 32'h0000_0FFF);
    plan_beat(8'h01, CHK_TYPED_NONE, 0, 0, '0);
    // A zero side counts as one; the ramp now starts at all zeros.
    plan_reg(gbg_pkg::CFG_ORIGIN_Y, 32'd7);
    plan_reg(gbg_pkg::CFG_START_COLOR, 32'h0000_0000);
    plan_reg(gbg_pkg::CFG_END_COLOR, 32'hFFFF_FFFF);
    plan_reg(gbg_pkg::CFG_GLYPH_ROWS, 32'd0);
    plan_reg(gbg_pkg::CFG_GLYPH_WIDTH, 32'd0);
    plan_beat(8'h81, CHK_TYPED_WRITE, 5, 7, 32'h0000_0000);
    // An oversize side is clamped to the largest glyph.
    plan_reg(gbg_pkg::CFG_GLYPH_ROWS, 32'h0000_01FF);
    plan_reg(gbg_pkg::CFG_GLYPH_WIDTH, 32'd2);
    plan_beat(8'h10, CHK_MODEL, 0, 0, '0);
    plan_beat(8'hC0, CHK_MODEL, 0, 0, '0);
    // Rewriting the geometry in the middle of a column restarts the walk.
    plan_reg(gbg_pkg::CFG_GLYPH_ROWS, 32'd3);
    plan_beat(8'h20, CHK_MODEL, 0, 0, '0);
    plan_beat(8'h20, CHK_MODEL, 0, 0, '0);
    plan_reg(gbg_pkg::CFG_GLYPH_ROWS, 32'd3);
    plan_beat(8'h20, CHK_MODEL, 0, 0, '0);
    // Writes to indexes with no register behind them change nothing.
    plan_reg(CFG_UNMAPPED_LO, 32'hFFFF_FFFF);
    plan_reg(CFG_UNMAPPED_HI, 32'h0000_0000);
    plan_beat(8'h90, CHK_MODEL, 0, 0, '0);
    plan_beat(8'h90, CHK_MODEL, 0, 0, '0);
    plan_beat(8'h90, CHK_MODEL, 0, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_idx, plan[i].data);
      else send_beat(plan[i].cov, plan[i].mode, plan[i].typed);
    end

    // Random phases. Each one may place a new glyph, change its shape or
    // recolor the ramp, then streams a run of beats under random idling.
    phase = 0;
    while (beats_sent < TARGET_BEATS - CALM_BEATS) begin
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        write_reg(gbg_pkg::CFG_GLYPH_WIDTH, pick_side(6));
        write_reg(gbg_pkg::CFG_GLYPH_ROWS, pick_side(30));
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(gbg_pkg::CFG_ORIGIN_X, pick_origin(gbg_pkg::SCREEN_WIDTH_DEF));
        write_reg(gbg_pkg::CFG_ORIGIN_Y, pick_origin(gbg_pkg::SCREEN_HEIGHT_DEF));
      end
      if ($urandom_range(0, 1) == 0) begin
        top_color = pick_color();
        write_reg(gbg_pkg::CFG_START_COLOR, top_color);
        write_reg(gbg_pkg::CFG_END_COLOR,
                  $urandom_range(0, 3) == 0 ? top_color : pick_color());
      end
      case ($urandom_range(0, 3))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 10;
        default: send_gap_pct = 30;
      endcase
      case ($urandom_range(0, 3))
        0:       recv_stall_pct = 0;
        1:       recv_stall_pct = 10;
        default: recv_stall_pct = 30;
      endcase

      if (phase == 3) begin
        // Back-pressure run: each first-half beat paints a visible pixel while
        // the result side holds off, so the block fills and stops taking beats.
        // Halfway through, the sender pauses until every write has landed.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_reg(gbg_pkg::CFG_ORIGIN_X, 32'd100);
        write_reg(gbg_pkg::CFG_ORIGIN_Y, 32'd100);
        hold_req++;
        repeat (PRESSURE_BEATS)
          send_beat(gbg_pkg::COVERAGE_W'($urandom_range(1, 255) | 1), CHK_MODEL, '0);
        wait_drained();
        repeat (PRESSURE_BEATS) send_beat(pick_coverage(), CHK_MODEL, '0);
      end else begin
        phase_beats = $urandom_range(10, 60);
        repeat (phase_beats) send_beat(pick_coverage(), CHK_MODEL, '0);
      end
      phase++;
    end

    // Closing stretch with no idling on either side.
    wait_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (CALM_BEATS) send_beat(pick_coverage(), CHK_MODEL, '0);
    wait_drained();

    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
